// File: rtl/apdr_pkg.sv
// ----------------------------------------------------------------------------
// Allpass delay reverb stage package
// Shared widths, codes, types and the sample saturation function.
// ----------------------------------------------------------------------------
`default_nettype none

package apdr_pkg;

  localparam int MAX_DELAY       = 4096;
  localparam int SAMPLE_BITS     = 24;
  localparam int EXCURSION_SLACK = 13 * 2;

  localparam int PTR_W      = $clog2(MAX_DELAY);
  localparam int LEN_W      = PTR_W + 1;
  localparam int BASE_W     = 12;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 15;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int MUL_A_W  = SAMPLE_BITS + 1;
  localparam int MUL_B_W  = FRAC_W + 2;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int SAT_IN_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_BASE      = 2'd0,
    CFG_FEEDBACK_GAIN   = 2'd1,
    CFG_INTERP_FRACTION = 2'd2
  } apdr_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INTERP_MUL,
    ST_INTERP,
    ST_FB_MUL,
    ST_TAP,
    ST_OUT_MUL,
    ST_OUT
  } apdr_state_e;

  typedef struct packed {
    logic                          en;
    logic [PTR_W-1:0]              addr;
    logic signed [SAMPLE_BITS-1:0] data;
  } apdr_wr_t;

  localparam logic signed [SAT_IN_W-1:0] SAMPLE_MAX =
    {{(SAT_IN_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAT_IN_W-1:0] SAMPLE_MIN = ~SAMPLE_MAX;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SAT_IN_W-1:0] v
  );
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SAMPLE_MAX) begin
      r = SAMPLE_MAX[SAMPLE_BITS-1:0];
    end else if (v < SAMPLE_MIN) begin
      r = SAMPLE_MIN[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/apdr_stream_if.sv
// ----------------------------------------------------------------------------
// Allpass delay reverb stage stream interfaces
// Valid/ready channels for input and output sample words.
// ----------------------------------------------------------------------------
`default_nettype none

interface apdr_in_if import apdr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface apdr_out_if import apdr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// File: rtl/apdr_delay_mem.sv
// ----------------------------------------------------------------------------
// Allpass delay reverb stage delay memory
// Circular sample store with registered read; unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module apdr_delay_mem import apdr_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          rd_en_i,
  input  wire logic [PTR_W-1:0]              rd_addr_i,
  output logic signed [SAMPLE_BITS-1:0]      rd_data_o,
  input  wire apdr_wr_t                      wr_i
);

  // The write address only ever steps by one or returns to zero, so the
  // written entries always form a prefix of the memory.
  logic signed [SAMPLE_BITS-1:0] mem [MAX_DELAY];
  logic signed [SAMPLE_BITS-1:0] rd_q;
  logic                          hit_q;
  logic [LEN_W-1:0]              fill_q, fill_d;
  logic [LEN_W-1:0]              wr_next;

  assign wr_next = {1'b0, wr_i.addr} + LEN_W'(1);

  always_comb begin
    fill_d = fill_q;
    if (wr_i.en && (wr_next > fill_q)) begin
      fill_d = wr_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q  <= mem[rd_addr_i];
      hit_q <= ({1'b0, rd_addr_i} < fill_q);
    end
  end

  assign rd_data_o = hit_q ? rd_q : '0;

endmodule

`default_nettype wire

// File: rtl/allpass_delay_reverb_stage_top.sv
// ----------------------------------------------------------------------------
// Allpass delay reverb stage
// Schroeder allpass section on a circular delay memory with an allpass
// interpolator on the delayed tap.
// ----------------------------------------------------------------------------
// One sample word is taken at a time: the delay memory read is issued at the
// accepting edge, then three passes through a single shared multiplier follow,
// each followed by a rounding and saturation step, and the last step loads the
// result into the output register. The next input word is taken in the cycle
// after the result is loaded into the output register, so no new word is taken
// before the last one is through; a stalled output word holds the stage in its
// last step. Entries of the delay memory that have not been written since reset
// read as zero, tracked by a fill count, so no clearing pass is needed and the
// block is ready right after reset.
`default_nettype none

module allpass_delay_reverb_stage_top import apdr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  apdr_in_if.sink                    in_i,
  apdr_out_if.source                 out_o
);

  localparam logic [FRAC_W:0] FRAC_ONE = {1'b1, {FRAC_W{1'b0}}};

  apdr_state_e state_q, state_d;

  logic [BASE_W-1:0]             delay_base_q;
  logic signed [GAIN_W-1:0]      gain_q;
  logic [FRAC_W-1:0]             frac_q;

  logic [PTR_W-1:0]              rp_q, rp_d;
  logic [PTR_W-1:0]              wp_q, wp_d;
  logic signed [SAMPLE_BITS-1:0] prev_tap_q, prev_tap_d;
  logic signed [SAMPLE_BITS-1:0] prev_interp_q, prev_interp_d;

  logic signed [SAMPLE_BITS-1:0] sig_q, sig_d;
  logic signed [SAMPLE_BITS-1:0] x_q, x_d;
  logic signed [SAMPLE_BITS-1:0] y_q, y_d;
  logic signed [SAMPLE_BITS-1:0] tap_q, tap_d;
  logic signed [PROD_W-1:0]      prod_q, prod_d;

  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] out_sample_q, out_sample_d;

  logic                          in_fire;
  logic                          rd_en;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  apdr_wr_t                      wr;

  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]      mul_p;
  logic [FRAC_W:0]               one_minus_tau;

  logic signed [PROD_W-1:0]             rnd_interp, rnd_gain;
  logic signed [PROD_W-FRAC_W-1:0]      interp_part;
  logic signed [PROD_W-GAIN_FRAC-1:0]   gain_part;

  logic [LEN_W-1:0]              len_raw, buf_len;
  logic [LEN_W-1:0]              rp_inc, wp_inc;

  assign in_fire   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_sample_q;

  assign rd_en = in_fire;

  apdr_delay_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rp_q),
    .rd_data_o (rd_data),
    .wr_i      (wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_base_q <= '0;
      gain_q       <= '0;
      frac_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DELAY_BASE:      delay_base_q <= cfg_data_i[BASE_W-1:0];
        CFG_FEEDBACK_GAIN:   gain_q       <= cfg_data_i[GAIN_W-1:0];
        CFG_INTERP_FRACTION: frac_q       <= cfg_data_i[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_raw = {1'b0, delay_base_q} + LEN_W'(1 + EXCURSION_SLACK);
  assign buf_len = (len_raw > LEN_W'(MAX_DELAY)) ? LEN_W'(MAX_DELAY) : len_raw;
  assign rp_inc  = {1'b0, rp_q} + LEN_W'(1);
  assign wp_inc  = {1'b0, wp_q} + LEN_W'(1);

  assign one_minus_tau = FRAC_ONE - {1'b0, frac_q};

  always_comb begin
    case (state_q)
      ST_INTERP_MUL: begin
        mul_a = {rd_data[SAMPLE_BITS-1], rd_data}
              - {prev_interp_q[SAMPLE_BITS-1], prev_interp_q};
        mul_b = {1'b0, one_minus_tau};
      end
      ST_FB_MUL: begin
        mul_a = {y_q[SAMPLE_BITS-1], y_q};
        mul_b = {{(MUL_B_W-GAIN_W){gain_q[GAIN_W-1]}}, gain_q};
      end
      ST_OUT_MUL: begin
        mul_a = {tap_q[SAMPLE_BITS-1], tap_q};
        mul_b = {{(MUL_B_W-GAIN_W){gain_q[GAIN_W-1]}}, gain_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign rnd_interp  = prod_q + (PROD_W'(1) <<< (FRAC_W - 1));
  assign rnd_gain    = prod_q + (PROD_W'(1) <<< (GAIN_FRAC - 1));
  assign interp_part = rnd_interp[PROD_W-1:FRAC_W];
  assign gain_part   = rnd_gain[PROD_W-1:GAIN_FRAC];

  always_comb begin
    state_d       = state_q;
    sig_d         = sig_q;
    x_d           = x_q;
    y_d           = y_q;
    tap_d         = tap_q;
    prod_d        = prod_q;
    rp_d          = rp_q;
    wp_d          = wp_q;
    prev_tap_d    = prev_tap_q;
    prev_interp_d = prev_interp_q;
    out_sample_d  = out_sample_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    wr.en         = 1'b0;
    wr.addr       = wp_q;
    wr.data       = tap_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          sig_d   = in_i.sample_in;
          state_d = ST_INTERP_MUL;
        end
      end
      ST_INTERP_MUL: begin
        x_d     = rd_data;
        prod_d  = mul_p;
        state_d = ST_INTERP;
      end
      ST_INTERP: begin
        y_d     = sat_sample(SAT_IN_W'(interp_part) + SAT_IN_W'(prev_tap_q));
        state_d = ST_FB_MUL;
      end
      ST_FB_MUL: begin
        prod_d  = mul_p;
        state_d = ST_TAP;
      end
      ST_TAP: begin
        tap_d         = sat_sample(SAT_IN_W'(sig_q) + SAT_IN_W'(gain_part));
        wr.en         = 1'b1;
        wr.data       = tap_d;
        prev_tap_d    = x_q;
        prev_interp_d = y_q;
        rp_d          = (rp_inc >= buf_len) ? '0 : rp_inc[PTR_W-1:0];
        wp_d          = (wp_inc >= buf_len) ? '0 : wp_inc[PTR_W-1:0];
        state_d       = ST_OUT_MUL;
      end
      ST_OUT_MUL: begin
        prod_d  = mul_p;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_sample_d = sat_sample(SAT_IN_W'(y_q) - SAT_IN_W'(gain_part));
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      rp_q          <= PTR_W'(1);
      wp_q          <= '0;
      prev_tap_q    <= '0;
      prev_interp_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      rp_q          <= rp_d;
      wp_q          <= wp_d;
      prev_tap_q    <= prev_tap_d;
      prev_interp_q <= prev_interp_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sig_q        <= sig_d;
    x_q          <= x_d;
    y_q          <= y_d;
    tap_q        <= tap_d;
    prod_q       <= prod_d;
    out_sample_q <= out_sample_d;
  end

endmodule

`default_nettype wire

// File: rtl/apdr_checker.sv
// ----------------------------------------------------------------------------
// Allpass delay reverb stage checker
// Port-level timing checks on the stream channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module apdr_checker import apdr_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  apdr_in_if.sink    in_i,
  apdr_out_if.source out_o
);

  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready
  ) else $error("input ready right after an accepted word");

  a_result_from_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready)
  ) else $error("output word appeared while the stage was idle");

  a_min_latency: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !$rose(out_o.valid) ##1 !$rose(out_o.valid)
  ) else $error("output word appeared too soon after an accepted word");

  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.sample_out))
  ) else $error("stalled output word changed or was dropped");

endmodule

bind allpass_delay_reverb_stage_top apdr_checker u_apdr_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);

`default_nettype wire

// File: dv/allpass_delay_reverb_stage_top_tb.sv
// ----------------------------------------------------------------------------
// Allpass delay reverb stage testbench
// Streams sample words through the stage under several delay, gain and
// interpolator settings, with random idling on both channels, and compares
// every output word with a cycle-free software predictor of the allpass section.
// ----------------------------------------------------------------------------
module allpass_delay_reverb_stage_top_tb import apdr_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 5;
  localparam int IDLE_PCT        = 37;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int RAND_PHASES     = 8;
  localparam int WORDS_PER_PHASE = 228;

  localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  apdr_in_if  in_if ();
  apdr_out_if out_if ();

  allpass_delay_reverb_stage_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  logic signed [SAMPLE_BITS-1:0] line_mem [MAX_DELAY];
  int unsigned                   rd_ptr;
  int unsigned                   wr_ptr;
  logic signed [SAMPLE_BITS-1:0] last_tap;
  logic signed [SAMPLE_BITS-1:0] last_interp;
  logic [BASE_W-1:0]             base_q;
  logic signed [GAIN_W-1:0]      gain_q;
  logic [FRAC_W-1:0]             frac_q;

  logic [SAMPLE_BITS-1:0]        pending_words [$];
  logic signed [SAMPLE_BITS-1:0] expected_samples [$];
  int unsigned                   words_queued;
  int unsigned                   words_taken;
  int unsigned                   quiet_cycles;
  int unsigned                   errors;
  int unsigned                   idle_pct;
  bit                            in_took;

  function automatic longint clip_sample(input longint v);
    if (v > SAMPLE_HI) begin
      return SAMPLE_HI;
    end
    if (v < SAMPLE_LO) begin
      return SAMPLE_LO;
    end
    return v;
  endfunction

  function automatic longint round_half_up(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] allpass_step(
    input logic signed [SAMPLE_BITS-1:0] sig
  );
    longint      x;
    longint      y;
    longint      tap;
    longint      res;
    longint      g;
    int unsigned len;
    x   = line_mem[rd_ptr];
    g   = gain_q;
    len = base_q + EXCURSION_SLACK + 1;
    if (len > MAX_DELAY) begin
      len = MAX_DELAY;
    end
    y = clip_sample(round_half_up((x - longint'(last_interp)) *
                                  (65536 - longint'(frac_q)), 16) + longint'(last_tap));
    tap = clip_sample(longint'(sig) + round_half_up(y * g, GAIN_FRAC));
    res = clip_sample(y - round_half_up(tap * g, GAIN_FRAC));
    line_mem[wr_ptr] = tap[SAMPLE_BITS-1:0];
    last_tap         = x[SAMPLE_BITS-1:0];
    last_interp      = y[SAMPLE_BITS-1:0];
    rd_ptr++;
    wr_ptr++;
    if (rd_ptr >= len) begin
      rd_ptr = 0;
    end
    if (wr_ptr >= len) begin
      wr_ptr = 0;
    end
    return res[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_word();
    int unsigned pick;
    int          v;
    logic [31:0] w;
    pick = $urandom_range(9);
    v    = int'($urandom_range(2047)) - 1024;
    w    = $urandom;
    case (pick)
      0: begin
        return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      end
      1, 2: begin
        return v[SAMPLE_BITS-1:0];
      end
      default: begin
        return w[SAMPLE_BITS-1:0];
      end
    endcase
  endfunction

  task automatic push_word(input logic [SAMPLE_BITS-1:0] w);
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic wait_drained();
    while (words_taken != words_queued || expected_samples.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      CFG_DELAY_BASE: begin
        base_q = data[BASE_W-1:0];
      end
      CFG_FEEDBACK_GAIN: begin
        gain_q = data;
      end
      CFG_INTERP_FRACTION: begin
        frac_q = data;
      end
      default: begin
      end
    endcase
  endtask

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_took) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_if.valid     <= 1'b1;
          in_if.sample_in <= pending_words.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    logic signed [SAMPLE_BITS-1:0] want;
    if (rst_ni) begin
      in_took = in_if.valid && in_if.ready;
      if (in_took) begin
        expected_samples.push_back(allpass_step(in_if.sample_in));
        words_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample_out word, expected none, got %0d",
                   $time, out_if.sample_out);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (out_if.sample_out !== want) begin
            $display("%0t: sample_out mismatch, expected %0d, got %0d",
                     $time, want, out_if.sample_out);
            errors++;
          end
        end
      end
      if (in_took || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned base_v;
    logic [15:0] gain_v;
    logic [15:0] frac_v;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_DELAY_BASE;
    cfg_data        = '0;
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    out_if.ready    = 1'b0;
    for (int i = 0; i < MAX_DELAY; i++) begin
      line_mem[i] = '0;
    end
    rd_ptr       = 1;
    wr_ptr       = 0;
    last_tap     = '0;
    last_interp  = '0;
    base_q       = '0;
    gain_q       = '0;
    frac_q       = '0;
    words_queued = 0;
    words_taken  = 0;
    quiet_cycles = 0;
    errors       = 0;
    idle_pct     = IDLE_PCT;
    in_took      = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // A write to the unused register index must leave every setting alone.
    write_reg(CFG_IDX_UNUSED, 16'hFFFF);
    push_word(24'h7FFFFF);
    push_word(24'h800000);
    push_word(24'h000000);
    push_word(24'hFFFFFF);
    push_word(24'h000001);
    push_word(24'h555555);
    push_word(24'hAAAAAA);
    push_word(24'h7FFFFF);
    wait_drained();

    write_reg(CFG_DELAY_BASE, 16'h0000);
    write_reg(CFG_FEEDBACK_GAIN, 16'h7FFF);
    write_reg(CFG_INTERP_FRACTION, 16'h0000);
    repeat (3) push_word(24'h7FFFFF);
    repeat (3) push_word(24'h800000);
    push_word(24'h000000);
    push_word(24'h400000);
    wait_drained();

    write_reg(CFG_DELAY_BASE, 16'h0005);
    write_reg(CFG_FEEDBACK_GAIN, 16'h8000);
    write_reg(CFG_INTERP_FRACTION, 16'hFFFF);
    repeat (2) push_word(24'h7FFFFF);
    repeat (2) push_word(24'h800000);
    push_word(24'hFFFFFF);
    push_word(24'h000001);
    push_word(24'h555555);
    push_word(24'hAAAAAA);
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        2: base_v = 4095;
        3: base_v = 0;
        5: base_v = 4069;
        default: base_v = $urandom_range(64);
      endcase
      case (ph)
        1: gain_v = 16'h7FFF;
        4: gain_v = 16'h8000;
        default: gain_v = $urandom;
      endcase
      case (ph)
        1, 6: frac_v = 16'h0000;
        4: frac_v = 16'hFFFF;
        default: frac_v = $urandom;
      endcase
      write_reg(CFG_DELAY_BASE, {4'($urandom_range(15)), base_v[BASE_W-1:0]});
      write_reg(CFG_FEEDBACK_GAIN, gain_v);
      write_reg(CFG_INTERP_FRACTION, frac_v);
      idle_pct = (ph == 6) ? 0 : IDLE_PCT;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        push_word(rand_word());
        if (ph == 3 && n == WORDS_PER_PHASE / 2) begin
          wait_drained();
        end
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/apdr_pkg.sv
rtl/apdr_stream_if.sv
rtl/apdr_delay_mem.sv
rtl/allpass_delay_reverb_stage_top.sv
rtl/apdr_checker.sv
dv/allpass_delay_reverb_stage_top_tb.sv
